### rtl/core/sdspi_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI host engine package
// Shared types, codes and helper functions of the SPI-mode card host engine.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int CSD_BYTES   = 16;
  localparam int FRAME_BYTES = 6;
  localparam int BIDX_W      = 10;

  // request / event codes of an input item
  localparam logic [3:0] MODE_INIT   = 4'd0;
  localparam logic [3:0] MODE_READ   = 4'd1;
  localparam logic [3:0] MODE_WRITE  = 4'd2;
  localparam logic [3:0] MODE_SCOUNT = 4'd3;
  localparam logic [3:0] MODE_SYNC   = 4'd4;
  localparam logic [3:0] MODE_POFF   = 4'd5;
  localparam logic [3:0] MODE_SPI    = 4'd6;
  localparam logic [3:0] MODE_WBYTE  = 4'd7;
  localparam logic [3:0] MODE_TICK   = 4'd8;

  // completion status codes
  localparam logic [2:0] STS_OK    = 3'd0;
  localparam logic [2:0] STS_ERR   = 3'd1;
  localparam logic [2:0] STS_NRDY  = 3'd2;
  localparam logic [2:0] STS_WPROT = 3'd3;
  localparam logic [2:0] STS_PARAM = 3'd4;

  // card kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_MMC    = 3'd1;
  localparam logic [2:0] KIND_SD1    = 3'd2;
  localparam logic [2:0] KIND_SD2B   = 3'd3;
  localparam logic [2:0] KIND_SD2BLK = 3'd4;

  // command bytes (start bit and index)
  localparam logic [7:0] CMD0  = 8'h40;
  localparam logic [7:0] CMD1  = 8'h41;
  localparam logic [7:0] CMD8  = 8'h48;
  localparam logic [7:0] CMD9  = 8'h49;
  localparam logic [7:0] CMD12 = 8'h4C;
  localparam logic [7:0] CMD16 = 8'h50;
  localparam logic [7:0] CMD17 = 8'h51;
  localparam logic [7:0] CMD18 = 8'h52;
  localparam logic [7:0] CMD23 = 8'h57;
  localparam logic [7:0] CMD24 = 8'h58;
  localparam logic [7:0] CMD25 = 8'h59;
  localparam logic [7:0] CMD41 = 8'h69;
  localparam logic [7:0] CMD55 = 8'h77;
  localparam logic [7:0] CMD58 = 8'h7A;

  localparam logic [7:0]  BYTE_IDLE  = 8'hFF;
  localparam logic [7:0]  TOK_START  = 8'hFE;
  localparam logic [7:0]  TOK_MULTI  = 8'hFC;
  localparam logic [7:0]  TOK_STOP   = 8'hFD;
  localparam logic [4:0]  DRESP_OK   = 5'h05;
  localparam logic [4:0]  DRESP_MASK = 5'h1F;
  localparam logic [31:0] ARG_VCHECK = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS    = 32'h4000_0000;
  localparam logic [47:0] FRAME_CMD0 = 48'h4000_0000_0095;

  // configuration register indexes
  localparam logic [2:0] CFG_READY_TO  = 3'd0;
  localparam logic [2:0] CFG_INIT_TO   = 3'd1;
  localparam logic [2:0] CFG_DATA_TO   = 3'd2;
  localparam logic [2:0] CFG_RESP_TRY  = 3'd3;
  localparam logic [2:0] CFG_PUP_POLL  = 3'd4;
  localparam logic [2:0] CFG_WAKE      = 3'd5;
  localparam logic [2:0] CFG_ACC_TRY   = 3'd6;

  typedef enum logic [4:0] {
    PH_IDLE, PH_READY, PH_FRAME, PH_STUFF, PH_RESP, PH_OCR, PH_TOKEN,
    PH_DATA, PH_CRC, PH_WTOKEN, PH_WWAIT, PH_WDATA, PH_WCRC, PH_ACCEPT,
    PH_BUSY, PH_WAKE, PH_PPOLL, PH_PEND, PH_FINAL
  } phase_t;

  typedef enum logic [4:0] {
    SP_NONE, I_PWR, I_CMD0, I_CMD8, I_OCR8, I_V2_55, I_V2_41, I_58,
    I_OCR58, I_V1_55, I_V1_41, I_L_55, I_L_41, I_L_1, I_16,
    R_17, R_B1, R_18, R_BM, R_12, W_24, W_B1, W_55, W_23, W_25, W_BM,
    W_STOP, C_9, C_B, S_R
  } step_t;

  typedef enum logic [1:0] {OWN_CMD, OWN_TX, OWN_SYNC} owner_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [31:0] sector;
    logic [15:0] block_count;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
    logic        card_absent;
    logic        write_protect;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        chip_select;
    logic        read_valid;
    logic [7:0]  read_data;
    logic        read_last;
    logic        want_write_byte;
    logic        done_res;
    logic [2:0]  status;
    logic [2:0]  card_kind;
    logic [31:0] sector_count;
  } out_item_t;

  typedef struct packed {
    logic [15:0] ready_to;
    logic [15:0] init_to;
    logic [15:0] data_to;
    logic [7:0]  resp_tries;
    logic [15:0] pup_poll;
    logic [7:0]  wake_bytes;
    logic [7:0]  acc_tries;
  } cfg_t;

  typedef struct packed {
    step_t       step;
    logic [7:0]  code;
    logic [31:0] arg;
  } go_t;

  function automatic go_t mk_go(input step_t s, input logic [7:0] c, input logic [31:0] a);
    go_t g;
    g.step = s;
    g.code = c;
    g.arg  = a;
    return g;
  endfunction

  function automatic logic [7:0] frame_crc(input logic [7:0] c);
    if (c == CMD0) return 8'h95;
    else if (c == CMD8) return 8'h87;
    else return 8'h01;
  endfunction

  // capacity in 512-byte sectors from the CSD register
  function automatic logic [31:0] csd_capacity(input logic [CSD_BYTES-1:0][7:0] b);
    logic [15:0] c2;
    logic [4:0]  n;
    logic [12:0] c1;
    logic [31:0] cw;
    c2 = {b[8], b[9]} + 16'd1;
    n  = 5'(b[5][3:0]) + 5'(b[10][7]) + 5'({b[9][1:0], 1'b0}) + 5'd2;
    c1 = 13'(b[8][7:6]) + 13'({b[7], 2'b00}) + 13'({b[6][1:0], 10'd0}) + 13'd1;
    cw = 32'(c1);
    if (b[0][7:6] == 2'b01) return {6'd0, c2, 10'd0};
    else if (n >= 5'd9) return cw << (n - 5'd9);
    else return cw >> (5'd9 - n);
  endfunction

endpackage

### rtl/core/sdspi_ifs.sv
// ----------------------------------------------------------------------------
// SD SPI host engine channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface sdspi_in_if;
  import sdspi_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface sdspi_out_if;
  import sdspi_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

### rtl/core/sdspi_cfg_regs.sv
// ----------------------------------------------------------------------------
// SD SPI configuration registers
// Write-only timeout and poll limit registers.
// ----------------------------------------------------------------------------
module sdspi_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [15:0]         cfg_wdata,
  output sdspi_pkg::cfg_t     cfg
);
  import sdspi_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ready_to   <= 16'd500;
      cfg_r.init_to    <= 16'd1000;
      cfg_r.data_to    <= 16'd200;
      cfg_r.resp_tries <= 8'd10;
      cfg_r.pup_poll   <= 16'd8191;
      cfg_r.wake_bytes <= 8'd10;
      cfg_r.acc_tries  <= 8'd65;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_READY_TO: cfg_r.ready_to   <= cfg_wdata;
        CFG_INIT_TO:  cfg_r.init_to    <= cfg_wdata;
        CFG_DATA_TO:  cfg_r.data_to    <= cfg_wdata;
        CFG_RESP_TRY: cfg_r.resp_tries <= cfg_wdata[7:0];
        CFG_PUP_POLL: cfg_r.pup_poll   <= cfg_wdata;
        CFG_WAKE:     cfg_r.wake_bytes <= cfg_wdata[7:0];
        CFG_ACC_TRY:  cfg_r.acc_tries  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/sdspi_in_stage.sv
// ----------------------------------------------------------------------------
// SD SPI input register
// Holds one accepted input item until the engine consumes it.
// ----------------------------------------------------------------------------
module sdspi_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sdspi_pkg::in_item_t  in_item,
  input  logic                 take,
  output logic                 stg_valid,
  output sdspi_pkg::in_item_t  stg_item
);
  import sdspi_pkg::*;

  logic     stg_v_r;
  in_item_t stg_item_r;

  assign in_ready = !stg_v_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_ready) begin
      stg_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_item_r <= in_item;
    end
  end

  assign stg_valid = stg_v_r;
  assign stg_item  = stg_item_r;

endmodule

### rtl/core/sdspi_core.sv
// ----------------------------------------------------------------------------
// SD SPI sequencer
// Command, response, data block and init sequencing, one item each fire cycle.
// ----------------------------------------------------------------------------
module sdspi_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sdspi_pkg::cfg_t      cfg,
  input  logic                 fire,
  input  sdspi_pkg::in_item_t  item,
  output logic                 res_valid,
  output sdspi_pkg::out_item_t res
);
  import sdspi_pkg::*;

  phase_t      phase_r, phase_nxt;
  step_t       pstep_r, pstep_nxt;
  owner_t      owner_r, owner_nxt;
  logic [3:0]  req_r, req_nxt;
  logic [47:0] shift_r, shift_nxt;
  logic [15:0] long_r, long_nxt;
  logic [15:0] rdyt_r, rdyt_nxt;
  logic [15:0] poll_r, poll_nxt;
  logic [BIDX_W-1:0] bi_r, bi_nxt;
  logic [15:0] bl_r, bl_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [31:0] ocr_r, ocr_nxt;
  logic [31:0] secv_r, secv_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [2:0]  itype_r, itype_nxt;
  logic        notinit_r, notinit_nxt;
  logic [CSD_BYTES-1:0][7:0] csd_r, csd_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [2:0]  fleft_r, fleft_nxt;
  logic [7:0]  wtok_r, wtok_nxt;
  logic [2:0]  rst_r, rst_nxt;
  logic        tocsd_r, tocsd_nxt;
  logic        acc_r, acc_nxt;
  logic        pframe_r, pframe_nxt;
  logic        cs_r, cs_nxt;

  // action flags
  logic        rdy_f, rdy_ok, adv_f, go_f, txb_f, rs_f, ocr_f, rxb_f, rxb_csd;
  logic        fin_f, fini_f, wake_f, frame_f, resp_f, cmp_f;
  logic [7:0]  adv_r, txb_tok;
  logic [2:0]  fin_st, cmp_st;
  go_t         gq;
  logic        o_txv, o_rv, o_rl, o_want;
  logic [7:0]  o_tx, o_rd;
  logic [BIDX_W-1:0] bi_inc, blen;

  assign bi_inc = bi_r + BIDX_W'(1);
  assign blen   = tocsd_r ? BIDX_W'(CSD_BYTES) : BIDX_W'(BLOCK_BYTES);

  always_comb begin
    phase_nxt = phase_r;   pstep_nxt = pstep_r; owner_nxt = owner_r; req_nxt = req_r;
    shift_nxt = shift_r;   long_nxt = long_r;   rdyt_nxt = rdyt_r;   poll_nxt = poll_r;
    bi_nxt = bi_r;         bl_nxt = bl_r;       addr_nxt = addr_r;   ocr_nxt = ocr_r;
    secv_nxt = secv_r;     kind_nxt = kind_r;   itype_nxt = itype_r; notinit_nxt = notinit_r;
    csd_nxt = csd_r;       cmd_nxt = cmd_r;     fleft_nxt = fleft_r; wtok_nxt = wtok_r;
    rst_nxt = rst_r;       tocsd_nxt = tocsd_r; acc_nxt = acc_r;     pframe_nxt = pframe_r;
    cs_nxt = cs_r;
    rdy_f = 1'b0; rdy_ok = 1'b0; adv_f = 1'b0; adv_r = BYTE_IDLE; go_f = 1'b0;
    txb_f = 1'b0; txb_tok = TOK_START; rs_f = 1'b0; ocr_f = 1'b0; rxb_f = 1'b0;
    rxb_csd = 1'b0; fin_f = 1'b0; fini_f = 1'b0; fin_st = STS_OK; wake_f = 1'b0;
    frame_f = 1'b0; resp_f = 1'b0; cmp_f = 1'b0; cmp_st = STS_OK;
    gq = mk_go(SP_NONE, CMD0, 32'd0);
    o_txv = 1'b0; o_tx = 8'd0; o_rv = 1'b0; o_rd = 8'd0; o_rl = 1'b0; o_want = 1'b0;

    // dispatch the item
    if (fire) begin
      if (item.mode == MODE_TICK) begin
        if (long_r != 16'd0) long_nxt = long_r - 16'd1;
        if (rdyt_r != 16'd0) rdyt_nxt = rdyt_r - 16'd1;
      end else if (item.mode <= MODE_POFF) begin
        if (phase_r == PH_IDLE) begin
          req_nxt  = item.mode;
          secv_nxt = 32'd0;
          if (item.mode == MODE_INIT) begin
            if (item.card_absent) begin
              cmp_f = 1'b1; cmp_st = STS_NRDY;
            end else begin
              pstep_nxt = I_PWR; cs_nxt = 1'b0; bi_nxt = '0; pframe_nxt = 1'b1;
              if (cfg.wake_bytes == 8'd0) wake_f = 1'b1;
              else begin
                phase_nxt = PH_WAKE; o_txv = 1'b1; o_tx = BYTE_IDLE;
              end
            end
          end else if (item.mode == MODE_POFF) begin
            cmp_f = 1'b1; cmp_st = STS_OK;
          end else if ((item.mode == MODE_READ || item.mode == MODE_WRITE)
                       && item.block_count == 16'd0) begin
            cmp_f = 1'b1; cmp_st = STS_PARAM;
          end else if (notinit_r) begin
            cmp_f = 1'b1; cmp_st = STS_NRDY;
          end else if (item.mode == MODE_WRITE && item.write_protect) begin
            cmp_f = 1'b1; cmp_st = STS_WPROT;
          end else begin
            cs_nxt = 1'b1;
            if (item.mode == MODE_SCOUNT) begin
              go_f = 1'b1; gq = mk_go(C_9, CMD9, 32'd0);
            end else if (item.mode == MODE_SYNC) begin
              pstep_nxt = S_R; owner_nxt = OWN_SYNC; rs_f = 1'b1;
            end else begin
              addr_nxt = (kind_r == KIND_SD2BLK) ? item.sector : {item.sector[22:0], 9'd0};
              bl_nxt   = item.block_count;
              if (item.mode == MODE_READ) begin
                go_f = 1'b1;
                if (item.block_count == 16'd1) gq = mk_go(R_17, CMD17, addr_nxt);
                else gq = mk_go(R_18, CMD18, addr_nxt);
              end else begin
                go_f = 1'b1;
                if (item.block_count == 16'd1) gq = mk_go(W_24, CMD24, addr_nxt);
                else if (kind_r >= KIND_SD1 && kind_r <= KIND_SD2BLK)
                  gq = mk_go(W_55, CMD55, 32'd0);
                else gq = mk_go(W_25, CMD25, addr_nxt);
              end
            end
          end
        end
      end else if (item.mode == MODE_WBYTE) begin
        if (phase_r == PH_WWAIT) begin
          phase_nxt = PH_WDATA; o_txv = 1'b1; o_tx = item.write_byte;
        end
      end else if (item.mode == MODE_SPI && phase_r != PH_IDLE && phase_r != PH_WWAIT) begin
        unique case (phase_r)
          PH_READY: begin
            if (item.rx_byte == BYTE_IDLE) begin
              rdy_f = 1'b1; rdy_ok = 1'b1;
            end else if (rdyt_r == 16'd0) rdy_f = 1'b1;
            else begin
              o_txv = 1'b1; o_tx = BYTE_IDLE;
            end
          end
          PH_FRAME: begin
            fleft_nxt = fleft_r - 3'd1;
            if (fleft_nxt != 3'd0) begin
              o_txv = 1'b1; o_tx = shift_r[47:40]; shift_nxt = {shift_r[39:0], 8'd0};
            end else if (pframe_r) begin
              poll_nxt = cfg.pup_poll; phase_nxt = PH_PPOLL; o_txv = 1'b1; o_tx = BYTE_IDLE;
            end else if (cmd_r == CMD12) begin
              phase_nxt = PH_STUFF; o_txv = 1'b1; o_tx = BYTE_IDLE;
            end else resp_f = 1'b1;
          end
          PH_STUFF: resp_f = 1'b1;
          PH_RESP: begin
            if (item.rx_byte[7]) begin
              poll_nxt = {8'd0, poll_r[7:0] - 8'd1};
              if (poll_nxt != 16'd0) begin
                o_txv = 1'b1; o_tx = BYTE_IDLE;
              end else begin
                adv_f = 1'b1; adv_r = item.rx_byte;
              end
            end else begin
              adv_f = 1'b1; adv_r = item.rx_byte;
            end
          end
          PH_OCR: begin
            ocr_nxt = {ocr_r[23:0], item.rx_byte};
            bi_nxt  = bi_inc;
            if (bi_inc < BIDX_W'(4)) begin
              o_txv = 1'b1; o_tx = BYTE_IDLE;
            end else begin
              adv_f = 1'b1; adv_r = 8'd0;
            end
          end
          PH_TOKEN: begin
            if (item.rx_byte == BYTE_IDLE && long_r != 16'd0) begin
              o_txv = 1'b1; o_tx = BYTE_IDLE;
            end else if (item.rx_byte != TOK_START) begin
              adv_f = 1'b1; adv_r = 8'd1;
            end else begin
              bi_nxt = '0; phase_nxt = PH_DATA; o_txv = 1'b1; o_tx = BYTE_IDLE;
            end
          end
          PH_DATA: begin
            if (tocsd_r) csd_nxt[bi_r[3:0]] = item.rx_byte;
            else begin
              o_rv = 1'b1; o_rd = item.rx_byte;
              o_rl = (bi_r == BIDX_W'(BLOCK_BYTES - 1)) && (bl_r == 16'd1);
            end
            bi_nxt = bi_inc;
            if (bi_inc >= blen) begin
              bi_nxt = '0; phase_nxt = PH_CRC;
            end
            o_txv = 1'b1; o_tx = BYTE_IDLE;
          end
          PH_CRC: begin
            bi_nxt = bi_inc;
            if (bi_inc < BIDX_W'(2)) begin
              o_txv = 1'b1; o_tx = BYTE_IDLE;
            end else begin
              adv_f = 1'b1; adv_r = 8'd0;
            end
          end
          PH_WTOKEN: begin
            if (wtok_r == TOK_STOP) begin
              adv_f = 1'b1; adv_r = 8'd0;
            end else begin
              bi_nxt = '0; phase_nxt = PH_WWAIT; o_want = 1'b1;
            end
          end
          PH_WDATA: begin
            bi_nxt = bi_inc;
            if (bi_inc < BIDX_W'(BLOCK_BYTES)) begin
              phase_nxt = PH_WWAIT; o_want = 1'b1;
            end else begin
              bi_nxt = '0; phase_nxt = PH_WCRC; o_txv = 1'b1; o_tx = BYTE_IDLE;
            end
          end
          PH_WCRC: begin
            bi_nxt = bi_inc;
            if (bi_inc >= BIDX_W'(2)) begin
              poll_nxt = 16'(cfg.acc_tries); acc_nxt = 1'b0; phase_nxt = PH_ACCEPT;
            end
            o_txv = 1'b1; o_tx = BYTE_IDLE;
          end
          PH_ACCEPT: begin
            if ((item.rx_byte[4:0] & DRESP_MASK) == DRESP_OK) begin
              acc_nxt = 1'b1; phase_nxt = PH_BUSY;
            end else begin
              poll_nxt = {8'd0, poll_r[7:0] - 8'd1};
              if (poll_nxt == 16'd0) phase_nxt = PH_BUSY;
            end
            o_txv = 1'b1; o_tx = BYTE_IDLE;
          end
          PH_BUSY: begin
            if (item.rx_byte == 8'd0) begin
              o_txv = 1'b1; o_tx = BYTE_IDLE;
            end else begin
              adv_f = 1'b1; adv_r = acc_r ? 8'd0 : 8'd1;
            end
          end
          PH_WAKE: begin
            bi_nxt = bi_inc;
            if (bi_inc < BIDX_W'(cfg.wake_bytes)) begin
              o_txv = 1'b1; o_tx = BYTE_IDLE;
            end else wake_f = 1'b1;
          end
          PH_PPOLL: begin
            if (item.rx_byte != 8'h01 && poll_r != 16'd0) begin
              poll_nxt = poll_r - 16'd1;
            end else begin
              cs_nxt = 1'b0; phase_nxt = PH_PEND;
            end
            o_txv = 1'b1; o_tx = BYTE_IDLE;
          end
          PH_PEND: begin
            pframe_nxt = 1'b0; adv_f = 1'b1; adv_r = 8'd0;
          end
          PH_FINAL: begin
            cmp_f = 1'b1; cmp_st = rst_r;
          end
          default: ;
        endcase
      end
    end

    // card ready wait finished
    if (rdy_f) begin
      unique case (owner_r)
        OWN_CMD: begin
          if (rdy_ok) frame_f = 1'b1;
          else begin
            adv_f = 1'b1; adv_r = BYTE_IDLE;
          end
        end
        OWN_TX: begin
          if (rdy_ok) begin
            phase_nxt = PH_WTOKEN; o_txv = 1'b1; o_tx = wtok_r;
          end else begin
            adv_f = 1'b1; adv_r = 8'd1;
          end
        end
        default: begin
          adv_f = 1'b1; adv_r = rdy_ok ? 8'd0 : 8'd1;
        end
      endcase
    end

    // advance the sequence on a command or block outcome
    if (adv_f) begin
      unique case (pstep_r)
        I_PWR: begin
          cs_nxt = 1'b1; itype_nxt = KIND_NONE; go_f = 1'b1; gq = mk_go(I_CMD0, CMD0, 32'd0);
        end
        I_CMD0: begin
          if (adv_r == 8'd1) begin
            long_nxt = cfg.init_to; go_f = 1'b1; gq = mk_go(I_CMD8, CMD8, ARG_VCHECK);
          end else fini_f = 1'b1;
        end
        I_CMD8: begin
          if (adv_r == 8'd1) begin
            pstep_nxt = I_OCR8; ocr_f = 1'b1;
          end else begin
            go_f = 1'b1; gq = mk_go(I_V1_55, CMD55, 32'd0);
          end
        end
        I_OCR8: begin
          if (ocr_nxt[15:8] == 8'h01 && ocr_nxt[7:0] == 8'hAA) begin
            go_f = 1'b1; gq = mk_go(I_V2_55, CMD55, 32'd0);
          end else fini_f = 1'b1;
        end
        I_V2_55, I_V2_41: begin
          if (pstep_r == I_V2_55 && adv_r <= 8'd1) begin
            go_f = 1'b1; gq = mk_go(I_V2_41, CMD41, ARG_HCS);
          end else if (pstep_r == I_V2_55 || adv_r != 8'd0) begin
            // still busy: poll again while time remains
            go_f = (long_nxt != 16'd0);
            if (long_nxt != 16'd0) gq = mk_go(I_V2_55, CMD55, 32'd0);
            else fini_f = 1'b1;
          end else begin
            go_f = (long_nxt != 16'd0);
            if (long_nxt != 16'd0) gq = mk_go(I_58, CMD58, 32'd0);
            else fini_f = 1'b1;
          end
        end
        I_58: begin
          if (adv_r == 8'd0) begin
            pstep_nxt = I_OCR58; ocr_f = 1'b1;
          end else fini_f = 1'b1;
        end
        I_OCR58: begin
          itype_nxt = ocr_nxt[30] ? KIND_SD2BLK : KIND_SD2B; fini_f = 1'b1;
        end
        I_V1_55, I_V1_41: begin
          if (pstep_r == I_V1_55 && adv_r <= 8'd1) begin
            go_f = 1'b1; gq = mk_go(I_V1_41, CMD41, 32'd0);
          end else begin
            if (pstep_r == I_V1_55) itype_nxt = KIND_MMC;
            else itype_nxt = (adv_r <= 8'd1) ? KIND_SD1 : KIND_MMC;
            go_f = 1'b1;
            if (itype_nxt == KIND_SD1) gq = mk_go(I_L_55, CMD55, 32'd0);
            else gq = mk_go(I_L_1, CMD1, 32'd0);
          end
        end
        I_L_55, I_L_41, I_L_1: begin
          if (pstep_r == I_L_55 && adv_r <= 8'd1) begin
            go_f = 1'b1; gq = mk_go(I_L_41, CMD41, 32'd0);
          end else if (pstep_r != I_L_55 && adv_r == 8'd0) begin
            // card left idle: set block length, unless time ran out
            if (long_nxt == 16'd0) begin
              itype_nxt = KIND_NONE; fini_f = 1'b1;
            end else begin
              go_f = 1'b1; gq = mk_go(I_16, CMD16, 32'(BLOCK_BYTES));
            end
          end else if (long_nxt != 16'd0) begin
            go_f = 1'b1;
            if (itype_nxt == KIND_SD1) gq = mk_go(I_L_55, CMD55, 32'd0);
            else gq = mk_go(I_L_1, CMD1, 32'd0);
          end else begin
            itype_nxt = KIND_NONE; fini_f = 1'b1;
          end
        end
        I_16: begin
          if (adv_r != 8'd0) itype_nxt = KIND_NONE;
          fini_f = 1'b1;
        end
        R_17, R_18: begin
          if (adv_r == 8'd0) begin
            pstep_nxt = (pstep_r == R_17) ? R_B1 : R_BM; rxb_f = 1'b1;
          end else begin
            fin_f = 1'b1; fin_st = STS_ERR;
          end
        end
        R_B1, W_B1: begin
          if (adv_r == 8'd0) bl_nxt = 16'd0;
          fin_f = 1'b1; fin_st = (bl_nxt != 16'd0) ? STS_ERR : STS_OK;
        end
        R_BM: begin
          if (adv_r == 8'd0) bl_nxt = bl_r - 16'd1;
          if (adv_r == 8'd0 && bl_nxt != 16'd0) rxb_f = 1'b1;
          else begin
            go_f = 1'b1; gq = mk_go(R_12, CMD12, 32'd0);
          end
        end
        R_12: begin
          fin_f = 1'b1; fin_st = (bl_r != 16'd0) ? STS_ERR : STS_OK;
        end
        W_24, W_25: begin
          if (adv_r == 8'd0) begin
            txb_f = 1'b1;
            if (pstep_r == W_24) begin
              pstep_nxt = W_B1; txb_tok = TOK_START;
            end else begin
              pstep_nxt = W_BM; txb_tok = TOK_MULTI;
            end
          end else begin
            fin_f = 1'b1; fin_st = STS_ERR;
          end
        end
        W_55: begin
          go_f = 1'b1; gq = mk_go(W_23, CMD23, 32'(bl_r));
        end
        W_23: begin
          go_f = 1'b1; gq = mk_go(W_25, CMD25, addr_r);
        end
        W_BM: begin
          if (adv_r == 8'd0) bl_nxt = bl_r - 16'd1;
          txb_f = 1'b1;
          if (adv_r == 8'd0 && bl_nxt != 16'd0) txb_tok = TOK_MULTI;
          else begin
            pstep_nxt = W_STOP; txb_tok = TOK_STOP;
          end
        end
        W_STOP: begin
          if (adv_r != 8'd0) bl_nxt = 16'd1;
          fin_f = 1'b1; fin_st = (bl_nxt != 16'd0) ? STS_ERR : STS_OK;
        end
        C_9: begin
          if (adv_r == 8'd0) begin
            pstep_nxt = C_B; rxb_f = 1'b1; rxb_csd = 1'b1;
          end else begin
            fin_f = 1'b1; fin_st = STS_ERR;
          end
        end
        C_B: begin
          fin_f = 1'b1;
          if (adv_r == 8'd0) begin
            secv_nxt = csd_capacity(csd_r); fin_st = STS_OK;
          end else fin_st = STS_ERR;
        end
        S_R: begin
          fin_f = 1'b1; fin_st = (adv_r == 8'd0) ? STS_OK : STS_ERR;
        end
        default: begin
          fin_f = 1'b1; fin_st = STS_ERR;
        end
      endcase
    end

    // close initialization: latch card kind, report result
    if (fini_f) begin
      kind_nxt = itype_nxt;
      if (itype_nxt != KIND_NONE) notinit_nxt = 1'b0;
      fin_f  = 1'b1;
      fin_st = notinit_nxt ? STS_NRDY : STS_OK;
    end

    if (go_f) begin
      pstep_nxt  = gq.step;
      cmd_nxt    = gq.code;
      pframe_nxt = 1'b0;
      shift_nxt  = {gq.code, gq.arg, frame_crc(gq.code)};
      owner_nxt  = OWN_CMD;
      rs_f       = 1'b1;
    end
    if (txb_f) begin
      wtok_nxt = txb_tok; owner_nxt = OWN_TX; rs_f = 1'b1;
    end
    if (rs_f) begin
      rdyt_nxt = cfg.ready_to; phase_nxt = PH_READY; o_txv = 1'b1; o_tx = BYTE_IDLE;
    end
    if (ocr_f) begin
      bi_nxt = '0; phase_nxt = PH_OCR; o_txv = 1'b1; o_tx = BYTE_IDLE;
    end
    if (rxb_f) begin
      tocsd_nxt = rxb_csd; long_nxt = cfg.data_to; phase_nxt = PH_TOKEN;
      o_txv = 1'b1; o_tx = BYTE_IDLE;
    end
    if (fin_f) begin
      rst_nxt = fin_st; cs_nxt = 1'b0; phase_nxt = PH_FINAL; o_txv = 1'b1; o_tx = BYTE_IDLE;
    end
    if (wake_f) begin
      cs_nxt = 1'b1; shift_nxt = FRAME_CMD0; frame_f = 1'b1;
    end
    if (frame_f) begin
      fleft_nxt = 3'(FRAME_BYTES); phase_nxt = PH_FRAME;
      o_txv = 1'b1; o_tx = shift_nxt[47:40]; shift_nxt = {shift_nxt[39:0], 8'd0};
    end
    if (resp_f) begin
      poll_nxt = 16'(cfg.resp_tries); phase_nxt = PH_RESP; o_txv = 1'b1; o_tx = BYTE_IDLE;
    end
    if (cmp_f) begin
      phase_nxt = PH_IDLE; pstep_nxt = SP_NONE;
    end
  end

  // result record
  always_comb begin
    res_valid           = fire && (o_txv || o_rv || o_want || cmp_f);
    res.tx_valid        = o_txv;
    res.tx_byte         = o_txv ? o_tx : 8'd0;
    res.chip_select     = cs_nxt;
    res.read_valid      = o_rv;
    res.read_data       = o_rv ? o_rd : 8'd0;
    res.read_last       = o_rl;
    res.want_write_byte = o_want;
    res.done_res        = cmp_f;
    res.status          = cmp_f ? cmp_st : STS_OK;
    res.card_kind       = kind_nxt;
    res.sector_count    = (cmp_f && req_nxt == MODE_SCOUNT && cmp_st == STS_OK)
                          ? secv_nxt : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;  pstep_r <= SP_NONE; owner_r <= OWN_CMD; req_r <= MODE_INIT;
      shift_r <= '0;       long_r <= '0;       rdyt_r <= '0;       poll_r <= '0;
      bi_r <= '0;          bl_r <= '0;         addr_r <= '0;       ocr_r <= '0;
      secv_r <= '0;        kind_r <= KIND_NONE; itype_r <= KIND_NONE; notinit_r <= 1'b1;
      cmd_r <= '0;         fleft_r <= '0;      wtok_r <= '0;       rst_r <= STS_OK;
      tocsd_r <= 1'b0;     acc_r <= 1'b0;      pframe_r <= 1'b0;   cs_r <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt; pstep_r <= pstep_nxt; owner_r <= owner_nxt; req_r <= req_nxt;
      shift_r <= shift_nxt; long_r <= long_nxt;   rdyt_r <= rdyt_nxt;   poll_r <= poll_nxt;
      bi_r <= bi_nxt;       bl_r <= bl_nxt;       addr_r <= addr_nxt;   ocr_r <= ocr_nxt;
      secv_r <= secv_nxt;   kind_r <= kind_nxt;   itype_r <= itype_nxt;
      notinit_r <= notinit_nxt;
      cmd_r <= cmd_nxt;     fleft_r <= fleft_nxt; wtok_r <= wtok_nxt;   rst_r <= rst_nxt;
      tocsd_r <= tocsd_nxt; acc_r <= acc_nxt;     pframe_r <= pframe_nxt; cs_r <= cs_nxt;
    end
  end

  // CSD bytes hold no reset value; only read once all sixteen arrived
  always_ff @(posedge clk) begin
    if (fire) begin
      csd_r <= csd_nxt;
    end
  end

endmodule

### rtl/core/sdspi_out_reg.sv
// ----------------------------------------------------------------------------
// SD SPI result register
// Holds one result record until the consumer takes it.
// ----------------------------------------------------------------------------
module sdspi_out_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  sdspi_pkg::out_item_t  res,
  output logic                  free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sdspi_pkg::out_item_t  out_item
);
  import sdspi_pkg::*;

  logic      out_v_r;
  out_item_t out_item_r;

  assign free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (free) begin
      out_v_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_item  = out_item_r;

endmodule

### rtl/core/sd_card_spi_host_engine_unit.sv
// ----------------------------------------------------------------------------
// SD card SPI host engine
// SPI-mode card initialization, block read/write, capacity and sync sequencer.
// ----------------------------------------------------------------------------
//
//  port    | direction | flow control | carries
//  in_ch   | sink      | valid/ready  | request, received SPI byte, write byte, tick
//  out_ch  | source    | valid/ready  | byte to send, chip select, read data, status
//  cfg_*   | sink      | write enable | timeouts and poll limits, write only
//
//  One input item is taken per cycle while the output register is free.
//  It is held in the input register; the engine consumes it and loads its
//  result record (if any) into the output register, which keeps it until
//  the consumer takes it. The engine only moves when the output register is
//  free: a stalled consumer holds the engine and then the input. Synchronous
//  reset puts the sequencer idle with the card deselected and uninitialized.
//
module sd_card_spi_host_engine_unit (
  input  logic          clk,
  input  logic          rst_n,
  sdspi_in_if.sink      in_ch,
  sdspi_out_if.source   out_ch,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_idx,
  input  logic [15:0]   cfg_wdata
);
  import sdspi_pkg::*;

  cfg_t      cfg;
  logic      stg_valid;
  in_item_t  stg_item;
  logic      out_free;
  logic      fire;
  logic      res_valid;
  out_item_t res;

  // the engine consumes the held item whenever a result can be stored
  assign fire = stg_valid && out_free;

  sdspi_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sdspi_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_item   (in_ch.item),
    .take      (out_free),
    .stg_valid (stg_valid),
    .stg_item  (stg_item)
  );

  sdspi_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .fire      (fire),
    .item      (stg_item),
    .res_valid (res_valid),
    .res       (res)
  );

  // ticks and ignored items produce nothing; only real records are loaded
  sdspi_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .free      (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.item)
  );

endmodule

### dv/sd_card_spi_host_engine_unit_test.sv
// ----------------------------------------------------------------------------
// SD card SPI host engine testbench
// Drives requests and card replies into the engine and predicts every result
// record with a cycle-free model of the sequencer held in the scoreboard.
// ----------------------------------------------------------------------------
import sdspi_pkg::*;

class card_engine_tracker;
  logic [15:0] regs[7];
  phase_t      ph;
  step_t       st;
  logic [3:0]  req;
  owner_t      owner;
  logic [47:0] cmd_sh;
  logic [15:0] long_t, ready_t, polls, bidx, left, blen;
  logic [31:0] addr, ocr, cap;
  logic [2:0]  ctype, itype, res_st, frame_left;
  logic        not_init, powered;
  logic [7:0]  csd[16];
  logic [7:0]  cmd_code, wr_tok;
  bit          to_csd, accepted, pframe, cs;
  out_item_t   o;
  out_item_t   expected_records[$];
  int          mismatches;

  function new();
    regs = '{16'd500, 16'd1000, 16'd200, 16'd10, 16'd8191, 16'd10, 16'd65};
    ph = PH_IDLE; st = SP_NONE; req = '0; owner = OWN_CMD; cmd_sh = '0;
    long_t = '0; ready_t = '0; polls = '0; bidx = '0; left = '0; blen = 16'd512;
    addr = '0; ocr = '0; cap = '0; ctype = KIND_NONE; itype = '0; res_st = '0;
    frame_left = '0; not_init = 1'b1; powered = 1'b0; cmd_code = '0; wr_tok = '0;
    foreach (csd[i]) csd[i] = '0;
    to_csd = 0; accepted = 0; pframe = 0; cs = 0; mismatches = 0;
  endfunction

  function void set_reg(int idx, logic [15:0] v);
    regs[idx] = (idx == CFG_RESP_TRY || idx == CFG_WAKE || idx == CFG_ACC_TRY) ?
                {8'd0, v[7:0]} : v;
  endfunction

  function int pending();
    return expected_records.size();
  endfunction

  function void emit(logic [7:0] b);
    o.tx_valid = 1'b1;
    o.tx_byte  = b;
  endfunction

  function void frame_byte();
    emit(cmd_sh[47:40]);
    cmd_sh = {cmd_sh[39:0], 8'h00};
  endfunction

  function void open_frame();
    frame_left = 3'd6; ph = PH_FRAME; frame_byte();
  endfunction

  function void wait_ready();
    ready_t = regs[CFG_READY_TO]; ph = PH_READY; emit(BYTE_IDLE);
  endfunction

  function void go(step_t s, logic [7:0] c, logic [31:0] arg);
    logic [7:0] crc;
    crc = (c == CMD0) ? 8'h95 : (c == CMD8) ? 8'h87 : 8'h01;
    st = s; cmd_code = c; pframe = 0;
    cmd_sh = {c, arg, crc};
    owner = OWN_CMD;
    wait_ready();
  endfunction

  function void poll_resp();
    polls = {8'd0, regs[CFG_RESP_TRY][7:0]}; ph = PH_RESP; emit(BYTE_IDLE);
  endfunction

  function void fetch_ocr();
    bidx = '0; ph = PH_OCR; emit(BYTE_IDLE);
  endfunction

  function void rx_block(logic [15:0] len, bit into_csd);
    blen = len; to_csd = into_csd; long_t = regs[CFG_DATA_TO];
    ph = PH_TOKEN; emit(BYTE_IDLE);
  endfunction

  function void tx_block(logic [7:0] tok);
    wr_tok = tok; owner = OWN_TX; wait_ready();
  endfunction

  function void wake_end();
    cs = 1; cmd_sh = FRAME_CMD0; open_frame();
  endfunction

  function void power_up();
    cs = 0; bidx = '0; pframe = 1;
    if (regs[CFG_WAKE] == 0) begin
      wake_end();
    end else begin
      ph = PH_WAKE; emit(BYTE_IDLE);
    end
  endfunction

  function void wrap_up(logic [2:0] s);
    res_st = s; cs = 0; ph = PH_FINAL; emit(BYTE_IDLE);
  endfunction

  function void report_done(logic [2:0] s);
    ph = PH_IDLE; st = SP_NONE;
    o.done_res = 1'b1; o.status = s;
    o.sector_count = (req == MODE_SCOUNT && s == STS_OK) ? cap : 32'd0;
  endfunction

  function void capacity();
    logic [15:0] c16;
    logic [31:0] c;
    int n;
    if (csd[0][7:6] == 2'b01) begin
      c16 = {csd[8], csd[9]} + 16'd1;
      cap = {16'd0, c16} << 10;
    end else begin
      n = csd[5][3:0] + csd[10][7] + (csd[9][1:0] << 1) + 2;
      c = 32'(csd[8][7:6]) + (32'(csd[7]) << 2) + (32'(csd[6][1:0]) << 10) + 32'd1;
      cap = (n >= 9) ? (c << (n - 9)) : (c >> (9 - n));
    end
  endfunction

  function void close_init();
    ctype = itype;
    if (itype != 0) not_init = 0;
    else powered = 0;
    wrap_up(not_init ? STS_NRDY : STS_OK);
  endfunction

  function void v2_after();
    if (long_t != 0) go(I_58, CMD58, 0); else close_init();
  endfunction

  function void v2_tail();
    if (long_t != 0) go(I_V2_55, CMD55, 0); else v2_after();
  endfunction

  function void v1_loop();
    if (itype == KIND_SD1) go(I_L_55, CMD55, 0); else go(I_L_1, CMD1, 0);
  endfunction

  function void v1_end();
    if (long_t == 0) begin
      itype = KIND_NONE; close_init();
    end else begin
      go(I_16, CMD16, 32'd512);
    end
  endfunction

  function void v1_tail();
    if (long_t != 0) v1_loop(); else v1_end();
  endfunction

  // move the command sequence on by one response
  function void advance(logic [7:0] r);
    case (st)
      I_PWR: begin
        cs = 1; itype = KIND_NONE; go(I_CMD0, CMD0, 0);
      end
      I_CMD0: begin
        if (r == 1) begin
          long_t = regs[CFG_INIT_TO]; go(I_CMD8, CMD8, ARG_VCHECK);
        end else close_init();
      end
      I_CMD8: begin
        if (r == 1) begin
          st = I_OCR8; fetch_ocr();
        end else go(I_V1_55, CMD55, 0);
      end
      I_OCR8: begin
        if (ocr[15:8] == 8'h01 && ocr[7:0] == 8'hAA) go(I_V2_55, CMD55, 0);
        else close_init();
      end
      I_V2_55: if (r <= 1) go(I_V2_41, CMD41, ARG_HCS); else v2_tail();
      I_V2_41: if (r == 0) v2_after(); else v2_tail();
      I_58: begin
        if (r == 0) begin
          st = I_OCR58; fetch_ocr();
        end else close_init();
      end
      I_OCR58: begin
        itype = ocr[30] ? KIND_SD2BLK : KIND_SD2B; close_init();
      end
      I_V1_55: begin
        if (r <= 1) go(I_V1_41, CMD41, 0);
        else begin
          itype = KIND_MMC; v1_loop();
        end
      end
      I_V1_41: begin
        itype = (r <= 1) ? KIND_SD1 : KIND_MMC; v1_loop();
      end
      I_L_55: if (r <= 1) go(I_L_41, CMD41, 0); else v1_tail();
      I_L_41, I_L_1: if (r == 0) v1_end(); else v1_tail();
      I_16: begin
        if (r != 0) itype = KIND_NONE;
        close_init();
      end
      R_17, R_18: begin
        if (r == 0) begin
          st = (st == R_17) ? R_B1 : R_BM; rx_block(16'd512, 0);
        end else wrap_up(STS_ERR);
      end
      R_B1, W_B1: begin
        if (r == 0) left = '0;
        wrap_up(left != 0 ? STS_ERR : STS_OK);
      end
      R_BM: begin
        if (r == 0) left = left - 1;
        if (r == 0 && left != 0) rx_block(16'd512, 0);
        else go(R_12, CMD12, 0);
      end
      R_12: wrap_up(left != 0 ? STS_ERR : STS_OK);
      W_24: begin
        if (r == 0) begin
          st = W_B1; tx_block(TOK_START);
        end else wrap_up(STS_ERR);
      end
      W_55: go(W_23, CMD23, {16'd0, left});
      W_23: go(W_25, CMD25, addr);
      W_25: begin
        if (r == 0) begin
          st = W_BM; tx_block(TOK_MULTI);
        end else wrap_up(STS_ERR);
      end
      W_BM: begin
        if (r == 0) left = left - 1;
        if (r == 0 && left != 0) tx_block(TOK_MULTI);
        else begin
          st = W_STOP; tx_block(TOK_STOP);
        end
      end
      W_STOP: begin
        if (r != 0) left = 16'd1;
        wrap_up(left != 0 ? STS_ERR : STS_OK);
      end
      C_9: begin
        if (r == 0) begin
          st = C_B; rx_block(16'd16, 1);
        end else wrap_up(STS_ERR);
      end
      C_B: begin
        if (r == 0) begin
          capacity(); wrap_up(STS_OK);
        end else wrap_up(STS_ERR);
      end
      S_R: wrap_up(r == 0 ? STS_OK : STS_ERR);
      default: wrap_up(STS_ERR);
    endcase
  endfunction

  function void ready_done(bit ok);
    if (owner == OWN_CMD) begin
      if (ok) open_frame(); else advance(8'hFF);
    end else if (owner == OWN_TX) begin
      if (ok) begin
        ph = PH_WTOKEN; emit(wr_tok);
      end else advance(8'd1);
    end else advance(ok ? 8'd0 : 8'd1);
  endfunction

  function void on_spi(logic [7:0] rx);
    case (ph)
      PH_READY: begin
        if (rx == 8'hFF) ready_done(1);
        else if (ready_t == 0) ready_done(0);
        else emit(BYTE_IDLE);
      end
      PH_FRAME: begin
        frame_left = frame_left - 1;
        if (frame_left != 0) frame_byte();
        else if (pframe) begin
          polls = regs[CFG_PUP_POLL]; ph = PH_PPOLL; emit(BYTE_IDLE);
        end else if (cmd_code == CMD12) begin
          ph = PH_STUFF; emit(BYTE_IDLE);
        end else poll_resp();
      end
      PH_STUFF: poll_resp();
      PH_RESP: begin
        if (rx[7]) begin
          polls = {8'd0, polls[7:0] - 8'd1};
          if (polls != 0) emit(BYTE_IDLE); else advance(rx);
        end else advance(rx);
      end
      PH_OCR: begin
        ocr = {ocr[23:0], rx}; bidx++;
        if (bidx < 4) emit(BYTE_IDLE); else advance(8'd0);
      end
      PH_TOKEN: begin
        if (rx == 8'hFF && long_t != 0) emit(BYTE_IDLE);
        else if (rx != TOK_START) advance(8'd1);
        else begin
          bidx = '0; ph = PH_DATA; emit(BYTE_IDLE);
        end
      end
      PH_DATA: begin
        if (to_csd) csd[bidx[3:0]] = rx;
        else begin
          o.read_valid = 1'b1; o.read_data = rx;
          o.read_last = (bidx == blen - 1 && left == 1);
        end
        bidx++;
        if (bidx >= blen) begin
          bidx = '0; ph = PH_CRC;
        end
        emit(BYTE_IDLE);
      end
      PH_CRC: begin
        bidx++;
        if (bidx < 2) emit(BYTE_IDLE); else advance(8'd0);
      end
      PH_WTOKEN: begin
        if (wr_tok == TOK_STOP) advance(8'd0);
        else begin
          bidx = '0; ph = PH_WWAIT; o.want_write_byte = 1'b1;
        end
      end
      PH_WDATA: begin
        bidx++;
        if (bidx < 512) begin
          ph = PH_WWAIT; o.want_write_byte = 1'b1;
        end else begin
          bidx = '0; ph = PH_WCRC; emit(BYTE_IDLE);
        end
      end
      PH_WCRC: begin
        bidx++;
        if (bidx < 2) emit(BYTE_IDLE);
        else begin
          polls = {8'd0, regs[CFG_ACC_TRY][7:0]}; accepted = 0;
          ph = PH_ACCEPT; emit(BYTE_IDLE);
        end
      end
      PH_ACCEPT: begin
        if ((rx & DRESP_MASK) == DRESP_OK) begin
          accepted = 1; ph = PH_BUSY;
        end else begin
          polls = {8'd0, polls[7:0] - 8'd1};
          if (polls == 0) ph = PH_BUSY;
        end
        emit(BYTE_IDLE);
      end
      PH_BUSY: if (rx == 0) emit(BYTE_IDLE); else advance(accepted ? 8'd0 : 8'd1);
      PH_WAKE: begin
        bidx++;
        if (bidx < regs[CFG_WAKE]) emit(BYTE_IDLE); else wake_end();
      end
      PH_PPOLL: begin
        if (rx != 8'h01 && polls != 0) begin
          polls--; emit(BYTE_IDLE);
        end else begin
          cs = 0; ph = PH_PEND; emit(BYTE_IDLE);
        end
      end
      PH_PEND: begin
        powered = 1; pframe = 0; advance(8'd0);
      end
      PH_FINAL: report_done(res_st);
      default: ;
    endcase
  endfunction

  function void start_request(in_item_t it);
    req = it.mode; cap = '0;
    if (it.mode == MODE_INIT) begin
      if (it.card_absent) report_done(STS_NRDY);
      else begin
        st = I_PWR; power_up();
      end
    end else if (it.mode == MODE_POFF) begin
      powered = 0; report_done(STS_OK);
    end else if ((it.mode == MODE_READ || it.mode == MODE_WRITE) && it.block_count == 0)
      report_done(STS_PARAM);
    else if (not_init) report_done(STS_NRDY);
    else if (it.mode == MODE_WRITE && it.write_protect) report_done(STS_WPROT);
    else begin
      cs = 1;
      if (it.mode == MODE_SCOUNT) go(C_9, CMD9, 0);
      else if (it.mode == MODE_SYNC) begin
        st = S_R; owner = OWN_SYNC; wait_ready();
      end else begin
        addr = (ctype == KIND_SD2BLK) ? it.sector : {it.sector[22:0], 9'd0};
        left = it.block_count;
        if (it.mode == MODE_READ) begin
          if (it.block_count == 1) go(R_17, CMD17, addr); else go(R_18, CMD18, addr);
        end else if (it.block_count == 1) go(W_24, CMD24, addr);
        else if (ctype >= KIND_SD1 && ctype <= KIND_SD2BLK) go(W_55, CMD55, 0);
        else go(W_25, CMD25, addr);
      end
    end
  endfunction

  // note an accepted input transfer and queue the record it causes
  function void note_transfer(in_item_t it);
    o = '0;
    if (it.mode == MODE_TICK) begin
      if (long_t != 0) long_t--;
      if (ready_t != 0) ready_t--;
      return;
    end
    if (it.mode <= MODE_POFF) begin
      if (ph == PH_IDLE) start_request(it);
    end else if (it.mode == MODE_SPI) begin
      if (ph != PH_IDLE && ph != PH_WWAIT) on_spi(it.rx_byte);
    end else if (it.mode == MODE_WBYTE) begin
      if (ph == PH_WWAIT) begin
        ph = PH_WDATA; emit(it.write_byte);
      end
    end
    if (o.tx_valid || o.read_valid || o.want_write_byte || o.done_res) begin
      o.chip_select = cs;
      o.card_kind = ctype;
      expected_records.push_back(o);
    end
  endfunction

  function void cmp(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
      mismatches++;
    end
  endfunction

  // check one result transfer against the oldest expectation
  function void check_result(out_item_t got);
    out_item_t e;
    if (expected_records.size() == 0) begin
      $error("unexpected result record %p", got);
      mismatches++;
      return;
    end
    e = expected_records.pop_front();
    cmp("tx_valid", e.tx_valid, got.tx_valid);
    cmp("tx_byte", e.tx_byte, got.tx_byte);
    cmp("chip_select", e.chip_select, got.chip_select);
    cmp("read_valid", e.read_valid, got.read_valid);
    cmp("read_data", e.read_data, got.read_data);
    cmp("read_last", e.read_last, got.read_last);
    cmp("want_write_byte", e.want_write_byte, got.want_write_byte);
    cmp("done_res", e.done_res, got.done_res);
    cmp("status", e.status, got.status);
    cmp("card_kind", e.card_kind, got.card_kind);
    cmp("sector_count", e.sector_count, got.sector_count);
  endfunction
endclass

module sd_card_spi_host_engine_unit_test;
  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [15:0] cfg_wdata;
  int          send_idle_pct;
  int          stall_pct;

  sdspi_in_if  in_ch();
  sdspi_out_if out_ch();

  card_engine_tracker tracker = new();

  sd_card_spi_host_engine_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  // Play the card: pick the reply to the exchange the engine is waiting on,
  // mostly the well-formed answer so sequences get deep, sometimes junk.
  function automatic in_item_t card_reply();
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.mode = MODE_SPI;
    case (tracker.ph)
      PH_READY: if (chance(85)) it.rx_byte = BYTE_IDLE;
      PH_RESP: begin
        if (chance(20)) it.rx_byte = 8'h80 | 8'($urandom);
        else begin
          case (tracker.st)
            I_CMD0:                 it.rx_byte = chance(90) ? 8'd1 : 8'($urandom);
            I_CMD8:                 it.rx_byte = chance(70) ? 8'd1 : 8'd5;
            I_V2_55, I_V1_55, I_L_55: it.rx_byte = chance(50) ? 8'd1 : 8'd0;
            I_V2_41, I_L_41, I_L_1: it.rx_byte = chance(50) ? 8'd0 : 8'd1;
            I_V1_41:                it.rx_byte = chance(50) ? 8'd1 : 8'd5;
            default: it.rx_byte = chance(90) ? 8'd0 : 8'($urandom_range(1, 127));
          endcase
        end
      end
      PH_OCR:
        if (tracker.st == I_OCR8 && chance(95))
          it.rx_byte = ARG_VCHECK[31 - 8 * tracker.bidx -: 8];
      PH_TOKEN: if (chance(70)) it.rx_byte = TOK_START;
                else if (chance(50)) it.rx_byte = BYTE_IDLE;
      PH_ACCEPT: if (chance(70)) it.rx_byte = {3'($urandom), DRESP_OK};
      PH_BUSY: it.rx_byte = chance(50) ? 8'd0 : 8'($urandom_range(1, 255));
      PH_PPOLL: if (chance(70)) it.rx_byte = 8'h01;
      PH_WWAIT: it.mode = MODE_WBYTE;
      default: ;
    endcase
    // ticks let timeouts expire; the odd stray item must be ignored
    if (chance(8)) it.mode = MODE_TICK;
    else if (chance(2)) it.mode = 4'($urandom);
    return it;
  endfunction

  // hold the item until its transfer, then maybe leave a gap
  task automatic send_item(in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.item  <= it;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_transfer(it);
    if (chance(send_idle_pct)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while (chance(send_idle_pct)) @(posedge clk);
    end
  endtask

  // issue one request and answer for the card until the engine is idle again
  task automatic run_request(logic [3:0] mode, logic [31:0] sec, logic [15:0] cnt,
                             bit absent, bit wp);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom, $urandom});
    it.mode = mode; it.sector = sec; it.block_count = cnt;
    it.card_absent = absent; it.write_protect = wp;
    send_item(it);
    while (tracker.ph != PH_IDLE) send_item(card_reply());
  endtask

  // drop valid so the last item is not sent again, then let results drain
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] v0, logic [15:0] v1, logic [15:0] v2,
                            logic [15:0] v3, logic [15:0] v4, logic [15:0] v5,
                            logic [15:0] v6);
    logic [15:0] vals[7];
    vals = '{v0, v1, v2, v3, v4, v5, v6};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1; cfg_idx <= 3'(i); cfg_wdata <= vals[i];
      @(posedge clk);
      tracker.set_reg(i, vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_request();
    int pick;
    logic [15:0] cnt;
    pick = $urandom_range(99);
    cnt = 16'($urandom_range(1, 3));
    if (pick < 20) run_request(MODE_INIT, $urandom, $urandom, chance(10), $urandom);
    else if (pick < 45)
      run_request(MODE_READ, $urandom, tracker.not_init ? 16'($urandom) : cnt, 0, $urandom);
    else if (pick < 70) begin
      // huge counts only where the write protect switch stops them
      if (chance(10)) run_request(MODE_WRITE, $urandom, $urandom, 0, 1);
      else run_request(MODE_WRITE, $urandom, chance(5) ? 16'd0 : cnt, 0, chance(10));
    end else if (pick < 80) run_request(MODE_SCOUNT, $urandom, $urandom, 0, $urandom);
    else if (pick < 95) run_request(MODE_SYNC, $urandom, $urandom, 0, $urandom);
    else run_request(MODE_POFF, $urandom, $urandom, 0, $urandom);
  endtask

  // flag results that land with no expectation as errors and compare the rest
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) tracker.check_result(out_ch.item);
    out_ch.ready <= !chance(stall_pct);
  end

  initial begin
    in_item_t it;
    send_idle_pct = 0;
    stall_pct     = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.item    = '0;
    out_ch.ready  = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stray items while idle must give nothing
    it = '0;
    it.mode = 4'd15;     send_item(it);
    it.mode = 4'd9;      send_item(it);
    it.mode = MODE_SPI;  it.rx_byte = 8'hFF; send_item(it);
    it.mode = MODE_WBYTE; it.write_byte = 8'hFF; send_item(it);
    it.mode = MODE_TICK; send_item(it);

    // refusals before the card is up: zero count, not initialized, absent card; then a power-off
    run_request(MODE_READ, 32'hFFFF_FFFF, 16'd0, 0, 0);
    run_request(MODE_WRITE, 32'd0, 16'd0, 0, 1);
    run_request(MODE_READ, 32'd0, 16'd1, 0, 0);
    run_request(MODE_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 0, 0);
    run_request(MODE_SCOUNT, 32'd0, 16'd0, 0, 0);
    run_request(MODE_SYNC, 32'd0, 16'd0, 0, 0);
    run_request(MODE_INIT, 32'd0, 16'd0, 1, 0);
    run_request(MODE_POFF, 32'd0, 16'd0, 0, 0);

    // bring the card up, then exercise read, write, capacity and sync requests
    repeat (3) if (tracker.not_init) run_request(MODE_INIT, 32'd0, 16'd0, 0, 0);
    run_request(MODE_WRITE, 32'hFFFF_FFFF, 16'hFFFF, 0, 1);
    run_request(MODE_READ, 32'hFFFF_FFFF, 16'd1, 0, 0);
    run_request(MODE_READ, 32'h0000_0001, 16'd2, 0, 0);
    run_request(MODE_WRITE, 32'h8000_0000, 16'd1, 0, 0);
    run_request(MODE_WRITE, 32'h7FFF_FFFF, 16'd2, 0, 0);
    run_request(MODE_SCOUNT, 32'd0, 16'd0, 0, 0);
    run_request(MODE_SYNC, 32'd0, 16'd0, 0, 0);
    drain();

    // idling phases, each with its own register setting
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct = 0; stall_pct = 0;
          write_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd1, 16'd1);
        end
        1: begin
          send_idle_pct = 65; stall_pct = 0;
          write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0);
        end
        2: begin
          send_idle_pct = 0; stall_pct = 65;
          write_regs(16'd255, 16'd40, 16'd30, 16'd255, 16'd50, 16'd255, 16'd255);
        end
        default: begin
          send_idle_pct = 8; stall_pct = 8;
          write_regs(16'($urandom_range(1, 60)), 16'($urandom_range(1, 60)),
                     16'($urandom_range(1, 60)), 16'($urandom),
                     16'($urandom_range(0, 40)), 16'($urandom), 16'($urandom));
        end
      endcase
      repeat (10) random_request();
      drain();
    end

    drain();
    if (tracker.pending() != 0) begin
      $error("%0d expected result records never arrived", tracker.pending());
      tracker.mismatches++;
    end
    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #40_000_000;
    $display("status: fail");
    $finish;
  end
endmodule
